FILE: rtl/sharpen_3x3_filter_unit_macros.svh
// Assertion helpers used by the filter unit RTL.
`ifndef SHARPEN_3X3_FILTER_UNIT_MACROS_SVH
`define SHARPEN_3X3_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SFU_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define SFU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SFU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFU_ASSERT(label, expr, msg)
`define SFU_ASSERT_IMP(label, ante, cons, msg)
`define SFU_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/shrp3_pkg.sv
package shrp3_pkg;

  localparam int FW_W        = 12;
  localparam int FH_W        = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int PIX_W       = 24;
  localparam int MAX_RESULTS = 4;
  localparam int FIFO_DEPTH  = 8;
  localparam int PTR_W       = 3;
  localparam int CNT_W       = 4;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;
  localparam logic [7:0]      CH_MAX           = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } shrp3_cfg_idx_e;

  typedef logic [PIX_W-1:0] shrp3_pix_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } shrp3_pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_run;
    logic       frame_done;
  } shrp3_pix_out_t;

  typedef struct packed {
    logic       r_ge1;
    logic       r_ge2;
    logic       col0;
    logic [3:0] mask;
  } shrp3_ctl_t;

  function automatic logic [2:0] cnt4(input logic [3:0] m);
    cnt4 = 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
  endfunction

  function automatic logic [7:0] sharpen_ch(input logic [7:0] ctr, input logic [7:0] up,
                                            input logic [7:0] dn, input logic [7:0] lf,
                                            input logic [7:0] rt);
    logic signed [11:0] acc;
    acc = $signed({2'b00, ctr, 2'b00}) + $signed({4'b0000, ctr})
        - $signed({4'b0000, up}) - $signed({4'b0000, dn})
        - $signed({4'b0000, lf}) - $signed({4'b0000, rt});
    if (acc[11]) begin
      sharpen_ch = 8'd0;
    end else if (acc > $signed({4'b0000, CH_MAX})) begin
      sharpen_ch = CH_MAX;
    end else begin
      sharpen_ch = acc[7:0];
    end
  endfunction

  function automatic shrp3_pix_t sharpen_pix(input shrp3_pix_t ctr, input shrp3_pix_t up,
                                             input shrp3_pix_t dn, input shrp3_pix_t lf,
                                             input shrp3_pix_t rt);
    shrp3_pix_t res;
    for (int k = 0; k < 3; k++) begin
      res[8*k +: 8] = sharpen_ch(ctr[8*k +: 8], up[8*k +: 8], dn[8*k +: 8],
                                 lf[8*k +: 8], rt[8*k +: 8]);
    end
    sharpen_pix = res;
  endfunction

endpackage

FILE: rtl/sharpen_3x3_filter_unit.sv
// Each accepted pixel passes registered stages B and C into an 8-entry result queue.
// Throughput: one pixel in and one result out per cycle, each while its side is ready.
// A pixel is taken only while the queue can absorb a worst-case burst of four results.
// Reset clears counters, handshakes and the queue, and sets the frame to 640 x 480.
// The line store is not cleared; it is written before it is read.
`include "sharpen_3x3_filter_unit_macros.svh"

module sharpen_3x3_filter_unit import shrp3_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  shrp3_pix_in_t         in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output shrp3_pix_out_t        out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCMP = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  logic [FW_W-1:0] cfg_width_q;
  logic [FH_W-1:0] cfg_height_q;
  logic [CW-1:0]   col_q;
  logic [FH_W-1:0] row_q;

  logic            in_fire;
  logic [WCMP-1:0] fw_ext;
  logic [WCMP-1:0] w_eff;
  logic [FH_W-1:0] h_eff;
  logic            at_edge;
  logic            at_last;
  shrp3_ctl_t      ctl_a;

  logic            valid_b_q;
  shrp3_ctl_t      ctl_b_q;
  shrp3_pix_t      pix_b_q;
  logic [CW-1:0]   ci_b_q;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [2*PIX_W-1:0] fwd_data_q;
  logic               fwd_q;
  logic [2*PIX_W-1:0] line_rd;
  shrp3_pix_t         mid_b;
  shrp3_pix_t         top_b;
  shrp3_pix_t         col_new [3];

  shrp3_pix_t win_q [3][3];
  logic       valid_c_q;
  logic [3:0] mask_c_q;
  shrp3_pix_t res [4];
  shrp3_pix_out_t entry [4];
  logic [PTR_W-1:0] slot [4];

  shrp3_pix_out_t   fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic [2:0]       n_b;
  logic [2:0]       n_c;
  logic             pop;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    fw_ext  = WCMP'(cfg_width_q);
    w_eff   = (fw_ext == '0) ? WCMP'(1) :
              ((fw_ext > WCMP'(MAX_WIDTH)) ? WCMP'(MAX_WIDTH) : fw_ext);
    h_eff   = (cfg_height_q == '0) ? FH_W'(1) : cfg_height_q;
    at_edge = (WCMP'(col_q) + WCMP'(1)) >= w_eff;
    at_last = ({1'b0, row_q} + 17'd1) >= {1'b0, h_eff};
    ctl_a.r_ge1 = row_q != '0;
    ctl_a.r_ge2 = row_q > FH_W'(1);
    ctl_a.col0  = col_q == '0;
    ctl_a.mask  = {at_last && at_edge, at_last && !ctl_a.col0,
                   ctl_a.r_ge1 && at_edge, ctl_a.r_ge1 && !ctl_a.col0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= FRAME_WIDTH_RST;
      cfg_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  cfg_width_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: cfg_height_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      valid_b_q <= 1'b0;
      ctl_b_q   <= '0;
      valid_c_q <= 1'b0;
      mask_c_q  <= '0;
      fwd_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        if (at_edge) begin
          col_q <= '0;
          row_q <= at_last ? '0 : row_q + FH_W'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
        ctl_b_q <= ctl_a;
      end
      valid_b_q <= in_fire;
      valid_c_q <= valid_b_q;
      if (valid_b_q) begin
        mask_c_q <= ctl_b_q.mask;
      end
      fwd_q <= valid_b_q && (ci_b_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pix_b_q <= in_data_i;
      ci_b_q  <= col_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q       <= line_mem[col_q];
    fwd_data_q <= {mid_b, pix_b_q};
    if (valid_b_q) begin
      line_mem[ci_b_q] <= {mid_b, pix_b_q};
    end
  end

  always_comb begin
    line_rd    = fwd_q ? fwd_data_q : rd_q;
    mid_b      = ctl_b_q.r_ge1 ? line_rd[PIX_W-1:0] : pix_b_q;
    top_b      = ctl_b_q.r_ge2 ? line_rd[2*PIX_W-1:PIX_W] : mid_b;
    col_new[0] = top_b;
    col_new[1] = mid_b;
    col_new[2] = pix_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (valid_b_q) begin
      for (int i = 0; i < 3; i++) begin
        if (ctl_b_q.col0) begin
          win_q[i][0] <= col_new[i];
          win_q[i][1] <= col_new[i];
        end else begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[i][2] <= col_new[i];
      end
    end
  end

  always_comb begin
    logic seen;
    res[0] = sharpen_pix(win_q[1][1], win_q[0][1], win_q[2][1], win_q[1][0], win_q[1][2]);
    res[1] = sharpen_pix(win_q[1][2], win_q[0][2], win_q[2][2], win_q[1][1], win_q[1][2]);
    res[2] = sharpen_pix(win_q[2][1], win_q[1][1], win_q[2][1], win_q[2][0], win_q[2][2]);
    res[3] = sharpen_pix(win_q[2][2], win_q[1][2], win_q[2][2], win_q[2][1], win_q[2][2]);
    seen = 1'b0;
    for (int k = 3; k >= 0; k--) begin
      entry[k].out_red     = res[k][23:16];
      entry[k].out_green   = res[k][15:8];
      entry[k].out_blue    = res[k][7:0];
      entry[k].last_of_run = !seen;
      entry[k].frame_done  = (k == 3);
      seen = seen | mask_c_q[k];
    end
    slot[0] = wr_ptr_q;
    for (int k = 1; k < 4; k++) begin
      slot[k] = slot[k-1] + PTR_W'(mask_c_q[k-1]);
    end
  end

  assign n_b = valid_b_q ? cnt4(ctl_b_q.mask) : 3'd0;
  assign n_c = valid_c_q ? cnt4(mask_c_q) : 3'd0;

  assign in_ready_o  = (5'(cnt_q) + 5'(n_b) + 5'(n_c)) <= 5'(FIFO_DEPTH - MAX_RESULTS);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (valid_c_q) begin
      for (int k = 0; k < 4; k++) begin
        if (mask_c_q[k]) begin
          fifo_q[slot[k]] <= entry[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(n_c);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      cnt_q    <= cnt_q + CNT_W'(n_c) - CNT_W'(pop);
    end
  end

  `SFU_ASSERT(a_queue_room, (5'(cnt_q) + 5'(n_c)) <= 5'(FIFO_DEPTH), "result queue overflow")
  `SFU_ASSERT_IMP(a_stage_b_src, valid_b_q, $past(in_fire), "stage B holds no transfer")
  `SFU_ASSERT_NXT(a_col_wrap, in_fire && at_edge, col_q == '0, "column did not wrap")
  `SFU_ASSERT_IMP(a_done_last, out_valid_o && out_data_o.frame_done,
                  out_data_o.last_of_run, "frame end is not last of run")

endmodule
